// ===== hw/rtl/gpg_pkg.sv =====
// Shared types, constants and register codes of the grid pressure gradient block.
// No dependencies; the module files of the block import it.
package gpg_pkg;

  localparam int ROW_BITS      = 6;
  localparam int COL_BITS      = 6;
  localparam int PRESS_BITS    = 32;
  localparam int GRAD_BITS     = 48;
  localparam int SIZE_BITS     = 7;
  localparam int STEP_BITS     = 32;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [SIZE_BITS-1:0] RST_SIZE = SIZE_BITS'(64);
  localparam logic [STEP_BITS-1:0] RST_STEP = STEP_BITS'(65536);

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROWS_USED  = 4'd0,
    REG_COLS_USED  = 4'd1,
    REG_INV_STEP_X = 4'd2,
    REG_INV_STEP_Y = 4'd3
  } gpg_reg_e;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_QUERY = 2'd1,
    OP_ZERO  = 2'd2
  } gpg_op_e;

  typedef struct packed {
    logic                         kind;
    logic [ROW_BITS-1:0]          row;
    logic [COL_BITS-1:0]          col;
    logic signed [PRESS_BITS-1:0] pressure;
  } gpg_item_t;

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic                        out_of_range;
  } gpg_result_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] value;
  } gpg_cfg_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] rows_used;
    logic [SIZE_BITS-1:0] cols_used;
    logic [STEP_BITS-1:0] inv_step_x;
    logic [STEP_BITS-1:0] inv_step_y;
  } gpg_regs_t;

  typedef struct packed {
    gpg_op_e                      op;
    logic                         oor;
    logic [ROW_BITS-1:0]          row;
    logic [COL_BITS-1:0]          col;
    logic [ROW_BITS-1:0]          row_hi;
    logic [ROW_BITS-1:0]          row_lo;
    logic [COL_BITS-1:0]          col_hi;
    logic [COL_BITS-1:0]          col_lo;
    logic                         cen_x;
    logic                         cen_y;
    logic signed [PRESS_BITS-1:0] pressure;
  } gpg_cmd_t;

endpackage

// ===== hw/rtl/gpg_stream_if.sv =====
// Valid/ready channel carrying one payload beat of a given type.
// Depends on nothing; the payload type is supplied where the channel is built.
interface gpg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/grid_pressure_gradient_2d.sv =====
// Pressure gradient on a 2D sample grid. A store is written in the back end's idle state.
// A query steps through S_RXL, S_RYH, S_RYL, S_DY, S_MY and S_OUT; an out-of-range or
// small-grid query gives its zero result from the idle state. Stores are taken one per cycle
// while the back end is idle; a query holds it until its result is loaded, using the single
// grid memory port (four sample reads) and the shared multiplier. Reset clears the
// queue, sequencer and result valid and reloads the registers; the grid stays undefined.
module grid_pressure_gradient_2d #(
  parameter int MAX_ROWS    = gpg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gpg_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = gpg_pkg::DEF_SAMPLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gpg_stream_if.sink   item_i,
  gpg_stream_if.source result_o,
  gpg_stream_if.sink   cfg_i
);
  import gpg_pkg::*;

  gpg_regs_t regs_q;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  gpg_cmd_t  fq_cmd, qb_cmd;

  // Configuration beats are always taken; an unknown index does nothing.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.rows_used  <= RST_SIZE;
      regs_q.cols_used  <= RST_SIZE;
      regs_q.inv_step_x <= RST_STEP;
      regs_q.inv_step_y <= RST_STEP;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_ROWS_USED:  regs_q.rows_used  <= cfg_i.data.value[SIZE_BITS-1:0];
        REG_COLS_USED:  regs_q.cols_used  <= cfg_i.data.value[SIZE_BITS-1:0];
        REG_INV_STEP_X: regs_q.inv_step_x <= cfg_i.data.value[STEP_BITS-1:0];
        REG_INV_STEP_Y: regs_q.inv_step_y <= cfg_i.data.value[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify each beat, drop stores outside the used grid.
  gpg_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .item        (item_i),
    .regs_i      (regs_q),
    .cmd_valid_o (fq_valid),
    .cmd_o       (fq_cmd),
    .cmd_ready_i (fq_ready)
  );

  // Queue: lets the front keep taking beats while the back end works.
  gpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_data_i  (fq_cmd),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_data_o   (qb_cmd),
    .pop_ready_i  (qb_ready)
  );

  // Back: grid memory, difference and scaling, result register.
  gpg_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .regs_i      (regs_q),
    .cmd_valid_i (qb_valid),
    .cmd_i       (qb_cmd),
    .cmd_ready_o (qb_ready),
    .result      (result_o)
  );

endmodule

// ===== hw/rtl/gpg_front.sv =====
// Front end: accepts item beats, checks them against the used grid and turns
// them into commands for the back end. Depends on gpg_pkg and gpg_stream_if.
module gpg_front #(
  parameter int MAX_ROWS = gpg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gpg_pkg::DEF_MAX_COLS
) (
  gpg_stream_if.sink          item,
  input  gpg_pkg::gpg_regs_t  regs_i,
  output logic                cmd_valid_o,
  output gpg_pkg::gpg_cmd_t   cmd_o,
  input  logic                cmd_ready_i
);
  import gpg_pkg::*;

  localparam int ROW_CLAMP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COL_CLAMP = (MAX_COLS > 127) ? 127 : MAX_COLS;

  typedef struct packed {
    logic [ROW_BITS-1:0] hi;
    logic [ROW_BITS-1:0] lo;
    logic                cen;
  } pair_t;

  // Neighbour pair along one axis: one-sided on the edges, central inside.
  function automatic pair_t pick_pair(input logic [ROW_BITS-1:0] pos,
                                      input logic [SIZE_BITS-1:0] n);
    pair_t                p;
    logic [SIZE_BITS-1:0] last;
    last = n - SIZE_BITS'(1);
    if (pos == '0) begin
      p.hi  = ROW_BITS'(1);
      p.lo  = '0;
      p.cen = 1'b0;
    end else if ({1'b0, pos} == last) begin
      p.hi  = last[ROW_BITS-1:0];
      p.lo  = last[ROW_BITS-1:0] - ROW_BITS'(1);
      p.cen = 1'b0;
    end else begin
      p.hi  = pos + ROW_BITS'(1);
      p.lo  = pos - ROW_BITS'(1);
      p.cen = 1'b1;
    end
    return p;
  endfunction

  logic [SIZE_BITS-1:0] nx, ny;
  logic                 in_grid, tiny_grid, drop;
  pair_t                px, py;

  always_comb begin
    nx = (regs_i.rows_used > SIZE_BITS'(ROW_CLAMP)) ? SIZE_BITS'(ROW_CLAMP) : regs_i.rows_used;
    ny = (regs_i.cols_used > SIZE_BITS'(COL_CLAMP)) ? SIZE_BITS'(COL_CLAMP) : regs_i.cols_used;
    in_grid   = ({1'b0, item.data.row} < nx) && ({1'b0, item.data.col} < ny);
    tiny_grid = (nx < SIZE_BITS'(2)) || (ny < SIZE_BITS'(2));
    px = pick_pair(item.data.row, nx);
    py = pick_pair(item.data.col, ny);

    cmd_o.oor      = !in_grid;
    cmd_o.row      = item.data.row;
    cmd_o.col      = item.data.col;
    cmd_o.row_hi   = px.hi;
    cmd_o.row_lo   = px.lo;
    cmd_o.col_hi   = py.hi;
    cmd_o.col_lo   = py.lo;
    cmd_o.cen_x    = px.cen;
    cmd_o.cen_y    = py.cen;
    cmd_o.pressure = item.data.pressure;

    if (item.data.kind == KIND_STORE) begin
      cmd_o.op = OP_STORE;
    end else if (!in_grid || tiny_grid) begin
      cmd_o.op = OP_ZERO;
    end else begin
      cmd_o.op = OP_QUERY;
    end

    // Drop stores outside the used grid here; they never reach the queue.
    drop        = (item.data.kind == KIND_STORE) && !in_grid;
    cmd_valid_o = item.valid && !drop;
    item.ready  = cmd_ready_i || drop;
  end

endmodule

// ===== hw/rtl/gpg_queue.sv =====
// Short command queue between front and back end.
// Depends on gpg_pkg for the command type.
module gpg_queue #(
  parameter int DEPTH = gpg_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  gpg_pkg::gpg_cmd_t push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output gpg_pkg::gpg_cmd_t pop_data_o,
  input  logic              pop_ready_i
);
  import gpg_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  gpg_cmd_t             slot_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 push, pop;

  always_comb begin
    push_ready_o = (cnt_q != CNT_BITS'(DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_data_o   = slot_q[rd_ptr_q];
    push = push_valid_i && push_ready_o;
    pop  = pop_valid_o && pop_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    cnt_d = cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/gpg_back.sv =====
// Back end: owns the sample grid memory, carries out stores and queries and
// holds the result register. Depends on gpg_pkg and gpg_stream_if.
module gpg_back #(
  parameter int MAX_ROWS    = gpg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gpg_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = gpg_pkg::DEF_SAMPLE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpg_pkg::gpg_regs_t regs_i,
  input  logic               cmd_valid_i,
  input  gpg_pkg::gpg_cmd_t  cmd_i,
  output logic               cmd_ready_o,
  gpg_stream_if.source       result
);
  import gpg_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = SAMPLE_BITS + 1;
  localparam int PW    = DW + STEP_BITS;
  localparam int EW    = (PW > GRAD_BITS + 1) ? PW : GRAD_BITS + 1;

  localparam logic [EW-1:0] POS_LIM = (EW'(1) << (GRAD_BITS - 1)) - EW'(1);
  localparam logic [EW-1:0] NEG_LIM = EW'(1) << (GRAD_BITS - 1);
  localparam logic [GRAD_BITS-1:0] POS_SAT = POS_LIM[GRAD_BITS-1:0];
  localparam logic [GRAD_BITS-1:0] NEG_SAT = NEG_LIM[GRAD_BITS-1:0];

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RXL  = 7'b0000010,
    S_RYH  = 7'b0000100,
    S_RYL  = 7'b0001000,
    S_DY   = 7'b0010000,
    S_MY   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [DW-1:0] mag;
    logic          neg;
  } absdiff_t;

  // Magnitude of hi - lo and whether the negated derivative comes out negative.
  function automatic absdiff_t abs_diff(input logic [SAMPLE_BITS-1:0] hi,
                                        input logic [SAMPLE_BITS-1:0] lo);
    absdiff_t      r;
    logic [DW-1:0] d;
    d = {hi[SAMPLE_BITS-1], hi} - {lo[SAMPLE_BITS-1], lo};
    r.mag = d[DW-1] ? (~d + DW'(1)) : d;
    r.neg = !d[DW-1] && (d != '0);
    return r;
  endfunction

  // Halve with rounding away from zero for central differences, then apply
  // the sign and clamp to the 48-bit range.
  function automatic logic [GRAD_BITS-1:0] sat_grad(input logic [PW-1:0] p,
                                                    input logic cen,
                                                    input logic neg);
    logic [EW-1:0]        pe;
    logic [GRAD_BITS-1:0] g;
    pe = cen ? (EW'(p >> 1) + EW'(p[0])) : EW'(p);
    if (neg) begin
      g = (pe > NEG_LIM) ? NEG_SAT : (~pe[GRAD_BITS-1:0] + GRAD_BITS'(1));
    end else begin
      g = (pe > POS_LIM) ? POS_SAT : pe[GRAD_BITS-1:0];
    end
    return g;
  endfunction

  state_e                 state_q, state_d;
  gpg_cmd_t               cmd_q;
  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q, hi_q;
  logic [DW-1:0]          mag_q;
  logic                   neg_q, pneg_q;
  logic [PW-1:0]          prod_q;
  logic [GRAD_BITS-1:0]   gx_q;
  logic                   res_valid_q, res_valid_d;
  gpg_result_t            res_q, res_d;

  logic [ROW_BITS-1:0]    row_sel;
  logic [COL_BITS-1:0]    col_sel;
  logic [AW-1:0]          addr;
  logic                   wr_en, out_free, load;
  absdiff_t               ad;

  assign out_free     = !res_valid_q || result.ready;
  assign result.valid = res_valid_q;
  assign result.data  = res_q;
  assign ad           = abs_diff(hi_q, rdata_q);

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    load        = 1'b0;
    res_d       = res_q;
    row_sel     = cmd_q.row;
    col_sel     = cmd_q.col;
    unique case (state_q)
      S_IDLE: begin
        row_sel = (cmd_i.op == OP_STORE) ? cmd_i.row : cmd_i.row_hi;
        col_sel = cmd_i.col;
        cmd_ready_o = (cmd_i.op != OP_ZERO) || out_free;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_STORE: wr_en = 1'b1;
            OP_QUERY: state_d = S_RXL;
            OP_ZERO: begin
              if (out_free) begin
                load               = 1'b1;
                res_d.grad_x       = '0;
                res_d.grad_y       = '0;
                res_d.out_of_range = cmd_i.oor;
              end
            end
            default: ;
          endcase
        end
      end
      S_RXL: begin
        row_sel = cmd_q.row_lo;
        state_d = S_RYH;
      end
      S_RYH: begin
        col_sel = cmd_q.col_hi;
        state_d = S_RYL;
      end
      S_RYL: begin
        col_sel = cmd_q.col_lo;
        state_d = S_DY;
      end
      S_DY:  state_d = S_MY;
      S_MY:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          load               = 1'b1;
          res_d.grad_x       = gx_q;
          res_d.grad_y       = sat_grad(prod_q, cmd_q.cen_y, pneg_q);
          res_d.out_of_range = 1'b0;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    addr = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
    res_valid_d = load ? 1'b1 : (result.ready ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Grid memory: one port, write or registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= cmd_i.pressure[SAMPLE_BITS-1:0];
    end
    rdata_q <= mem_q[addr];
  end

  // Datapath: differences, one shared multiplier, saturation.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if ((state_q == S_IDLE) && cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
    if ((state_q == S_RXL) || (state_q == S_RYL)) begin
      hi_q <= rdata_q;
    end
    if ((state_q == S_RYH) || (state_q == S_DY)) begin
      mag_q <= ad.mag;
      neg_q <= ad.neg;
    end
    if (state_q == S_RYL) begin
      prod_q <= PW'(mag_q) * PW'(regs_i.inv_step_x);
      pneg_q <= neg_q;
    end
    if (state_q == S_DY) begin
      gx_q <= sat_grad(prod_q, cmd_q.cen_x, pneg_q);
    end
    if (state_q == S_MY) begin
      prod_q <= PW'(mag_q) * PW'(regs_i.inv_step_y);
      pneg_q <= neg_q;
    end
  end

endmodule
